/* design/sbd_pkg.sv */
// sbd_pkg: shared types and constants for the spike blink detector
// register indexes, reset values, configuration and result structs
// no dependencies
`timescale 1ns / 1ps

package sbd_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_RISE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_PEAK_FLOOR     = 3'd1;
  localparam logic [2:0] REG_EMA_ALPHA      = 3'd2;
  localparam logic [2:0] REG_FALL_FRACTION  = 3'd3;
  localparam logic [2:0] REG_COOLDOWN_TICKS = 3'd4;
  localparam logic [2:0] REG_LIT_TICKS      = 3'd5;

  // register reset values
  localparam logic [14:0] RST_RISE_THRESHOLD = 15'd1200;
  localparam logic [14:0] RST_PEAK_FLOOR     = 15'd1800;
  localparam logic [15:0] RST_EMA_ALPHA      = 16'd65339;
  localparam logic [7:0]  RST_FALL_FRACTION  = 8'd102;
  localparam logic [15:0] RST_COOLDOWN_TICKS = 16'd350;
  localparam logic [15:0] RST_LIT_TICKS      = 16'd500;

  // input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // saturated tick count since the last blink
  localparam logic [15:0] SINCE_SAT = 16'hFFFF;

  // half lsb for round half up after the >> 16
  localparam logic [49:0] EMA_ROUND = 50'd32768;

  // alpha complement base, 1.0 in Q1.16
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  typedef struct packed {
    logic [14:0] rise_threshold;
    logic [14:0] peak_floor;
    logic [15:0] ema_alpha;
    logic [7:0]  fall_fraction;
    logic [15:0] cooldown_ticks;
    logic [15:0] lit_ticks;
  } cfg_t;

  typedef struct packed {
    logic        blink;
    logic        spiking;
    logic        lit;
    logic [15:0] blink_total;
    logic [15:0] magnitude;
    logic [15:0] baseline_level;
  } result_t;

endpackage

/* design/sbd_regs.sv */
// sbd_regs: APB-style configuration register file
// depends on sbd_pkg (cfg_t, register indexes, reset values)
`timescale 1ns / 1ps

module sbd_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sbd_pkg::cfg_t     cfg
);

  sbd_pkg::cfg_t cfg_r;
  sbd_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // register write decode, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        sbd_pkg::REG_RISE_THRESHOLD: cfg_nxt.rise_threshold = pwdata[14:0];
        sbd_pkg::REG_PEAK_FLOOR:     cfg_nxt.peak_floor     = pwdata[14:0];
        sbd_pkg::REG_EMA_ALPHA:      cfg_nxt.ema_alpha      = pwdata[15:0];
        sbd_pkg::REG_FALL_FRACTION:  cfg_nxt.fall_fraction  = pwdata[7:0];
        sbd_pkg::REG_COOLDOWN_TICKS: cfg_nxt.cooldown_ticks = pwdata[15:0];
        sbd_pkg::REG_LIT_TICKS:      cfg_nxt.lit_ticks      = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_threshold <= sbd_pkg::RST_RISE_THRESHOLD;
      cfg_r.peak_floor     <= sbd_pkg::RST_PEAK_FLOOR;
      cfg_r.ema_alpha      <= sbd_pkg::RST_EMA_ALPHA;
      cfg_r.fall_fraction  <= sbd_pkg::RST_FALL_FRACTION;
      cfg_r.cooldown_ticks <= sbd_pkg::RST_COOLDOWN_TICKS;
      cfg_r.lit_ticks      <= sbd_pkg::RST_LIT_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      sbd_pkg::REG_RISE_THRESHOLD: prdata = {17'd0, cfg_r.rise_threshold};
      sbd_pkg::REG_PEAK_FLOOR:     prdata = {17'd0, cfg_r.peak_floor};
      sbd_pkg::REG_EMA_ALPHA:      prdata = {16'd0, cfg_r.ema_alpha};
      sbd_pkg::REG_FALL_FRACTION:  prdata = {24'd0, cfg_r.fall_fraction};
      sbd_pkg::REG_COOLDOWN_TICKS: prdata = {16'd0, cfg_r.cooldown_ticks};
      sbd_pkg::REG_LIT_TICKS:      prdata = {16'd0, cfg_r.lit_ticks};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

/* design/sbd_core.sv */
// sbd_core: detector state and single-pass update for one request
// depends on sbd_pkg (cfg_t, result_t, mode codes, constants)
`timescale 1ns / 1ps

module sbd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              mode,
  input  logic [15:0]       sample,
  input  sbd_pkg::cfg_t     cfg,
  output sbd_pkg::result_t  res
);

  // detector state
  logic [31:0] base_r,     base_nxt;
  logic        seeded_r,   seeded_nxt;
  logic        spike_r,    spike_nxt;
  logic [15:0] peak_r,     peak_nxt;
  logic [15:0] count_r,    count_nxt;
  logic [15:0] since_r,    since_nxt;
  logic [15:0] lit_r,      lit_nxt;
  logic [15:0] last_mag_r, last_mag_nxt;
  logic        blink;

  // datapath terms
  logic [15:0] mag;
  logic [31:0] mag_fx;
  logic [16:0] alpha_c;
  logic [47:0] prod_old;
  logic [32:0] prod_new;
  logic [49:0] ema_acc;
  logic [31:0] ema_val;
  logic [32:0] rise_lim;
  logic        rise_hit;
  logic [15:0] peak_upd;
  logic [31:0] peak_fx;
  logic [31:0] range_fx;
  logic [39:0] range_scaled;
  logic [32:0] target;
  logic        fall_hit;
  logic        cool_ok;

  // magnitude, -32768 maps to 32768
  assign mag    = sample[15] ? (~sample + 16'd1) : sample;
  assign mag_fx = {mag, 16'd0};

  // exponential average of baseline and magnitude, round half up
  assign alpha_c  = sbd_pkg::ALPHA_ONE - {1'b0, cfg.ema_alpha};
  assign prod_old = cfg.ema_alpha * base_r;
  assign prod_new = alpha_c * mag;
  assign ema_acc  = {2'd0, prod_old} + {1'b0, prod_new, 16'd0} + sbd_pkg::EMA_ROUND;
  assign ema_val  = ema_acc[47:16];

  // spike entry test against the updated baseline
  assign rise_lim = {1'b0, ema_val} + {2'd0, cfg.rise_threshold, 16'd0};
  assign rise_hit = ({1'b0, mag_fx} > rise_lim) && (mag > {1'b0, cfg.peak_floor});

  // spike exit test: baseline plus a fraction of the peak range
  assign peak_upd     = (mag > peak_r) ? mag : peak_r;
  assign peak_fx      = {peak_upd, 16'd0};
  assign range_fx     = (peak_fx > base_r) ? (peak_fx - base_r) : 32'd0;
  assign range_scaled = range_fx * cfg.fall_fraction;
  assign target       = {1'b0, base_r} + {1'b0, range_scaled[39:8]};
  assign fall_hit     = {1'b0, mag_fx} < target;

  assign cool_ok = since_r > cfg.cooldown_ticks;

  // next state
  always_comb begin
    base_nxt     = base_r;
    seeded_nxt   = seeded_r;
    spike_nxt    = spike_r;
    peak_nxt     = peak_r;
    count_nxt    = count_r;
    since_nxt    = since_r;
    lit_nxt      = lit_r;
    last_mag_nxt = last_mag_r;
    blink        = 1'b0;
    if (mode == sbd_pkg::MODE_TICK) begin
      if (since_r != sbd_pkg::SINCE_SAT) begin
        since_nxt = since_r + 16'd1;
      end
      if (lit_r != 16'd0) begin
        lit_nxt = lit_r - 16'd1;
      end
    end else begin
      last_mag_nxt = mag;
      priority if (!seeded_r) begin
        base_nxt   = mag_fx;
        seeded_nxt = 1'b1;
      end else if (!spike_r) begin
        base_nxt = ema_val;
        if (rise_hit) begin
          spike_nxt = 1'b1;
          peak_nxt  = mag;
        end
      end else begin
        peak_nxt = peak_upd;
        if (fall_hit) begin
          spike_nxt = 1'b0;
          base_nxt  = ema_val;
          if ((peak_upd > {1'b0, cfg.peak_floor}) && cool_ok) begin
            count_nxt = count_r + 16'd1;
            since_nxt = 16'd0;
            lit_nxt   = cfg.lit_ticks;
            blink     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= 32'd0;
      seeded_r   <= 1'b0;
      spike_r    <= 1'b0;
      peak_r     <= 16'd0;
      count_r    <= 16'd0;
      since_r    <= sbd_pkg::SINCE_SAT;
      lit_r      <= 16'd0;
      last_mag_r <= 16'd0;
    end else if (adv) begin
      base_r     <= base_nxt;
      seeded_r   <= seeded_nxt;
      spike_r    <= spike_nxt;
      peak_r     <= peak_nxt;
      count_r    <= count_nxt;
      since_r    <= since_nxt;
      lit_r      <= lit_nxt;
      last_mag_r <= last_mag_nxt;
    end
  end

  // result fields seen after this request
  assign res.blink          = blink;
  assign res.spiking        = spike_nxt;
  assign res.lit            = (lit_nxt != 16'd0);
  assign res.blink_total    = count_nxt;
  assign res.magnitude      = last_mag_nxt;
  assign res.baseline_level = base_nxt[31:16];

endmodule

/* design/spike_blink_detector.sv */
// spike_blink_detector: requests pass an input register, then a result register with out_valid
// one request per cycle unless stalled; state updates in the same cycle as the result register
// the input register and the result register part the two channels, so a request is
// taken while a finished result still waits
// rst_n (synchronous) clears the detector state, the valid flags and the registers to defaults
`timescale 1ns / 1ps

module spike_blink_detector (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_blink,
  output logic        out_spiking,
  output logic        out_lit,
  output logic [15:0] out_blink_total,
  output logic [15:0] out_magnitude,
  output logic [15:0] out_baseline_level,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sbd_pkg::cfg_t    cfg;
  sbd_pkg::result_t res;
  sbd_pkg::result_t res_r;

  logic        in_valid_r;
  logic        in_mode_r;
  logic [15:0] in_sample_r;
  logic        out_valid_r;
  logic        adv;

  // advance when a request is held and the result slot is free or draining
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  sbd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .mode   (in_mode_r),
    .sample (in_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mode_r   <= in_mode;
      in_sample_r <= in_sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_blink          = res_r.blink;
  assign out_spiking        = res_r.spiking;
  assign out_lit            = res_r.lit;
  assign out_blink_total    = res_r.blink_total;
  assign out_magnitude      = res_r.magnitude;
  assign out_baseline_level = res_r.baseline_level;

  // a counted blink always closes the spike
  a_blink_ends_spike: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.blink |-> !res_r.spiking)
    else $error("blink reported while still inside a spike");

  // input side stalls only when both registers are full and the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("request side stalled without a full pipeline");

  // baseline never exceeds the largest magnitude
  a_baseline_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.baseline_level <= 16'd32768)
    else $error("baseline out of range");

endmodule

/* sim/testbench.sv */
// testbench: self-checking bench for spike_blink_detector, directed table then random episodes
// predicts untyped results with its own baseline/peak tracker and compares field by field
// depends on design/sbd_pkg.sv and design/spike_blink_detector.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam sbd_pkg::result_t ALL_CLEAR = '0;
  localparam sbd_pkg::result_t SEEDED_1000 = '{blink: 1'b0, spiking: 1'b0, lit: 1'b0,
                                               blink_total: 16'd0, magnitude: 16'd1000,
                                               baseline_level: 16'd1000};
  localparam sbd_pkg::cfg_t CFG_DEFAULT = '{sbd_pkg::RST_RISE_THRESHOLD,
                                            sbd_pkg::RST_PEAK_FLOOR,
                                            sbd_pkg::RST_EMA_ALPHA,
                                            sbd_pkg::RST_FALL_FRACTION,
                                            sbd_pkg::RST_COOLDOWN_TICKS,
                                            sbd_pkg::RST_LIT_TICKS};
  localparam sbd_pkg::cfg_t CFG_ZERO = '0;
  localparam sbd_pkg::cfg_t CFG_MAX = '1;

  typedef struct {
    logic             mode;
    logic [15:0]      sample;
    bit               typed;
    sbd_pkg::result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [15:0] in_sample;
  logic        out_valid;
  logic        out_ready;
  logic        out_blink;
  logic        out_spiking;
  logic        out_lit;
  logic [15:0] out_blink_total;
  logic [15:0] out_magnitude;
  logic [15:0] out_baseline_level;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spike_blink_detector dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_blink          (out_blink),
    .out_spiking        (out_spiking),
    .out_lit            (out_lit),
    .out_blink_total    (out_blink_total),
    .out_magnitude      (out_magnitude),
    .out_baseline_level (out_baseline_level),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // detector shadow: configuration and tracking state
  sbd_pkg::cfg_t cur_cfg = CFG_DEFAULT;
  logic [32:0] base_fx = '0;
  bit          seeded_q = 1'b0;
  bit          spike_q = 1'b0;
  logic [15:0] peak_q = '0;
  logic [15:0] count_q = '0;
  logic [15:0] since_q = sbd_pkg::SINCE_SAT;
  logic [15:0] lit_q = '0;
  logic [15:0] last_mag_q = '0;

  sbd_pkg::result_t pending_results[$];
  stim_row_t   directed_rows[19];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // sender idling
  bit          tx_idle_on = 1'b1;
  int unsigned tx_run_left = 0;

  // receiver stalls and the long hold-off
  bit          rx_idle_on = 1'b1;
  int unsigned rx_run_left = 0;
  int unsigned rx_left = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;

  // clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("out_%s got %0d expected %0d", name, got, want));
  endtask

  // baseline moving average, round half up
  function automatic void ema_track(input longint unsigned m);
    longint unsigned a;
    longint unsigned acc;
    a = longint'(cur_cfg.ema_alpha);
    acc = a * base_fx + (65536 - a) * (m << 16) + 32768;
    base_fx = acc[48:16];
  endfunction

  // one request through the detector shadow, returns the result it causes
  function automatic sbd_pkg::result_t detect_step(input logic mode,
                                                   input logic [15:0] smp);
    sbd_pkg::result_t r;
    bit              blink_now;
    longint unsigned mag;
    longint unsigned mag_fx;
    longint unsigned peak_fx;
    longint unsigned span;
    longint unsigned target;
    blink_now = 1'b0;
    if (mode == sbd_pkg::MODE_TICK) begin
      if (since_q != sbd_pkg::SINCE_SAT) since_q++;
      if (lit_q != 0) lit_q--;
    end else begin
      mag = smp[15] ? 65536 - longint'(smp) : longint'(smp);
      mag_fx = mag << 16;
      last_mag_q = mag[15:0];
      if (!seeded_q) begin
        // first sample seeds the baseline
        base_fx = mag_fx[32:0];
        seeded_q = 1'b1;
      end else if (!spike_q) begin
        ema_track(mag);
        if (mag_fx > base_fx + (longint'(cur_cfg.rise_threshold) << 16) &&
            mag > cur_cfg.peak_floor) begin
          spike_q = 1'b1;
          peak_q = mag[15:0];
        end
      end else begin
        // inside a spike: track peak, end below the fall target
        if (mag > peak_q) peak_q = mag[15:0];
        peak_fx = longint'(peak_q) << 16;
        span = (peak_fx > base_fx) ? peak_fx - base_fx : 0;
        target = base_fx + ((span * cur_cfg.fall_fraction) >> 8);
        if (mag_fx < target) begin
          spike_q = 1'b0;
          ema_track(mag);
          if (peak_q > cur_cfg.peak_floor && since_q > cur_cfg.cooldown_ticks) begin
            count_q++;
            since_q = '0;
            lit_q = cur_cfg.lit_ticks;
            blink_now = 1'b1;
          end
        end
      end
    end
    r.blink = blink_now;
    r.spiking = spike_q;
    r.lit = (lit_q != 0);
    r.blink_total = count_q;
    r.magnitude = last_mag_q;
    r.baseline_level = base_fx[31:16];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_run_left == 0) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      tx_run_left = $urandom_range(20, 80);
    end else begin
      tx_run_left--;
    end
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // magnitude 0..32768 to a sample of random sign
  function automatic logic [15:0] to_sample(input int unsigned m);
    logic [15:0] v;
    v = m[15:0];
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // offer one request and hold it until taken
  task automatic send_item(input logic mode, input logic [15:0] smp, input bit typed,
                           input sbd_pkg::result_t typed_res);
    int unsigned      gap;
    sbd_pkg::result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    predicted = detect_step(mode, smp);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic send_sample(input int unsigned m);
    send_item(sbd_pkg::MODE_SAMPLE, to_sample(m), 1'b0, ALL_CLEAR);
  endtask

  task automatic send_tick();
    send_item(sbd_pkg::MODE_TICK, 16'($urandom), 1'b0, ALL_CLEAR);
  endtask

  // random episodes: quiet stretch, optional tick run, rise, fall; plus noise
  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned kind;
    int unsigned quiet;
    int unsigned lo;
    int unsigned k;
    int unsigned i;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        quiet = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6000)
                                            : $urandom_range(0, 600);
        k = $urandom_range(2, 8);
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) == 0) send_tick();
          else send_sample($urandom_range(0, quiet));
        end
        sent += k;
        // tick run long enough to clear the cooldown, unless the 400-tick cap cuts it short
        if ($urandom_range(0, 7) == 0) begin
          k = cur_cfg.cooldown_ticks + $urandom_range(1, 4);
          if (k > 400) k = $urandom_range(1, 400);
          for (i = 0; i < k; i++) send_tick();
          sent += k;
        end
        lo = quiet + cur_cfg.rise_threshold + 1;
        if (lo < cur_cfg.peak_floor + 1) lo = cur_cfg.peak_floor + 1;
        if (lo > 32768) lo = 32768;
        k = $urandom_range(1, 4);
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) == 0) send_sample(32768);
          else send_sample($urandom_range(lo, 32768));
        end
        sent += k;
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) send_sample($urandom_range(0, quiet));
        sent += k;
      end else if (kind < 9) begin
        send_item(sbd_pkg::MODE_SAMPLE, 16'($urandom), 1'b0, ALL_CLEAR);
        sent++;
      end else begin
        send_tick();
        sent++;
      end
    end
  endtask

  // stop offering and wait until every result has come back
  task automatic settle_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      sbd_pkg::REG_RISE_THRESHOLD: cur_cfg.rise_threshold = val[14:0];
      sbd_pkg::REG_PEAK_FLOOR:     cur_cfg.peak_floor = val[14:0];
      sbd_pkg::REG_EMA_ALPHA:      cur_cfg.ema_alpha = val[15:0];
      sbd_pkg::REG_FALL_FRACTION:  cur_cfg.fall_fraction = val[7:0];
      sbd_pkg::REG_COOLDOWN_TICKS: cur_cfg.cooldown_ticks = val[15:0];
      sbd_pkg::REG_LIT_TICKS:      cur_cfg.lit_ticks = val[15:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(input sbd_pkg::cfg_t c);
    apb_write(sbd_pkg::REG_RISE_THRESHOLD, 32'(c.rise_threshold));
    apb_write(sbd_pkg::REG_PEAK_FLOOR, 32'(c.peak_floor));
    apb_write(sbd_pkg::REG_EMA_ALPHA, 32'(c.ema_alpha));
    apb_write(sbd_pkg::REG_FALL_FRACTION, 32'(c.fall_fraction));
    apb_write(sbd_pkg::REG_COOLDOWN_TICKS, 32'(c.cooldown_ticks));
    apb_write(sbd_pkg::REG_LIT_TICKS, 32'(c.lit_ticks));
  endtask

  // mostly modest thresholds and short timers so blinks come often
  function automatic sbd_pkg::cfg_t random_cfg();
    sbd_pkg::cfg_t c;
    c.rise_threshold = ($urandom_range(0, 4) == 0) ? 15'($urandom)
                                                   : 15'($urandom_range(0, 3000));
    c.peak_floor = ($urandom_range(0, 4) == 0) ? 15'($urandom)
                                               : 15'($urandom_range(0, 4000));
    c.ema_alpha = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(60000, 65535));
    c.fall_fraction = 8'($urandom);
    c.cooldown_ticks = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
    c.lit_ticks = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
    return c;
  endfunction

  // result receiver: random stalls, quiet stretches, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      rx_left = 300;
      out_ready <= 1'b0;
    end else if (rx_left != 0) begin
      rx_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_run_left == 0) begin
        rx_idle_on = ($urandom_range(0, 3) != 0);
        rx_run_left = $urandom_range(20, 80);
      end else begin
        rx_run_left--;
      end
      if (rx_idle_on && $urandom_range(0, 2) == 0)
        rx_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 40);
    end
  end

  // result checker
  always @(posedge clk) begin
    sbd_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("blink", out_blink, want.blink);
        compare_field("spiking", out_spiking, want.spiking);
        compare_field("lit", out_lit, want.lit);
        compare_field("blink_total", out_blink_total, want.blink_total);
        compare_field("magnitude", out_magnitude, want.magnitude);
        compare_field("baseline_level", out_baseline_level, want.baseline_level);
      end
    end
  end

  initial begin
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = sbd_pkg::MODE_SAMPLE;
    in_sample = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at reset settings
    directed_rows = '{
      '{sbd_pkg::MODE_TICK,   16'h1234, 1'b1, ALL_CLEAR},    // tick before any sample
      '{sbd_pkg::MODE_SAMPLE, 16'hFC18, 1'b1, SEEDED_1000},  // seeding sample, -1000
      '{sbd_pkg::MODE_SAMPLE, 16'h0001, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'hFFFF, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'h7FFF, 1'b0, ALL_CLEAR},    // spike starts
      '{sbd_pkg::MODE_SAMPLE, 16'h8000, 1'b0, ALL_CLEAR},    // largest magnitude, new peak
      '{sbd_pkg::MODE_TICK,   16'hFFFF, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'd20000, 1'b0, ALL_CLEAR},   // still above fall target
      '{sbd_pkg::MODE_SAMPLE, 16'h0000, 1'b0, ALL_CLEAR},    // spike ends, blink counted
      '{sbd_pkg::MODE_TICK,   16'h0000, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_TICK,   16'h5555, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'h7FFF, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'hFFFB, 1'b0, ALL_CLEAR},    // ends inside cooldown, no blink
      '{sbd_pkg::MODE_SAMPLE, 16'h8001, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'h0002, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'd1800, 1'b0, ALL_CLEAR},    // at the peak floor, not above
      '{sbd_pkg::MODE_SAMPLE, 16'h5555, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_SAMPLE, 16'hAAAA, 1'b0, ALL_CLEAR},
      '{sbd_pkg::MODE_TICK,   16'hAAAA, 1'b0, ALL_CLEAR}
    };
    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].sample, directed_rows[i].typed,
                directed_rows[i].want);
    run_random(280);
    settle_results();

    // extremes of every register
    write_cfg(CFG_ZERO);
    run_random(150);
    settle_results();
    write_cfg(CFG_MAX);
    run_random(150);
    settle_results();

    // random settings; the first phase holds the receiver off while requests keep coming
    for (ph = 0; ph < 4; ph++) begin
      write_cfg(random_cfg());
      if (ph == 0) begin
        tx_idle_on = 1'b0;
        tx_run_left = 400;
        hold_seq++;
      end
      run_random(250);
      settle_results();
    end

    write_cfg(CFG_DEFAULT);
    run_random(100);
    settle_results();

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
